FILE: src/ifse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ifse_pkg: shared types and constants of the info frame stuffing encoder
// Holds the channel payload structs, the command passed from the front end to
// the back end, the framing byte constants and the back end state encoding.
// ----------------------------------------------------------------------------
package ifse_pkg;

   // Framing and stuffing bytes.
   localparam logic [7:0] FLAG_BYTE  = 8'h7E;
   localparam logic [7:0] ESC_BYTE   = 8'h7D;
   localparam logic [7:0] ESC_XOR    = 8'h20;
   localparam logic [7:0] CTRL_SEQ0  = 8'h00;
   localparam logic [7:0] CTRL_SEQ1  = 8'h02;
   localparam logic [7:0] ADDR_RESET = 8'h05;

   // Command queue geometry.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_end;
      logic       seq_bit;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] line_byte;
      logic       burst_last;
      logic       frame_done;
   } rsp_payload_type;

   // One classified transaction, ready for the back end to serialize.
   typedef struct packed {
      logic       header;
      logic [7:0] addr;
      logic [7:0] ctrl;
      logic [7:0] data;
      logic       last;
      logic [7:0] bcc2;
   } cmd_type;

   // Handshake between the queue and the back end.
   typedef struct packed {
      logic valid;
      logic full;
   } queue_status_type;

   typedef enum logic [9:0] {
      ST_START      = 10'b00_0000_0001,
      ST_FLAG_OPEN  = 10'b00_0000_0010,
      ST_ADDR       = 10'b00_0000_0100,
      ST_CTRL       = 10'b00_0000_1000,
      ST_BCC1       = 10'b00_0001_0000,
      ST_DATA       = 10'b00_0010_0000,
      ST_DATA_ESC   = 10'b00_0100_0000,
      ST_BCC2       = 10'b00_1000_0000,
      ST_BCC2_ESC   = 10'b01_0000_0000,
      ST_FLAG_CLOSE = 10'b10_0000_0000
   } state_type;

   // True for a byte that must be escaped on the line.
   function automatic logic needs_escape(input logic [7:0] b);
      needs_escape = (b == FLAG_BYTE) || (b == ESC_BYTE);
   endfunction

endpackage : ifse_pkg
`default_nettype wire

FILE: src/info_frame_stuffing_encoder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// info_frame_stuffing_encoder_core: HDLC-like information frame encoder
// Frames payload bytes with flag, address, control and BCC1, byte-stuffs the
// payload and BCC2, and closes each frame with a flag.
//
//   Channel   Direction  Handshake            Transaction
//   req_*     in         req_valid/req_ready  one payload byte with marks
//   rsp_*     out        rsp_valid/rsp_ready  one line byte with marks
//   csr_*     in         csr_write_enable     address byte write
//
// One line byte leaves per cycle unless the queue is empty or the result
// channel stalls; a payload byte yields 1 to 9 line bytes in the back end
// sequencer (header 4, data 1 or 2, BCC2 1 or 2, closing flag 1). The front
// end takes a transaction per cycle while the two-entry command queue has
// room, so input stalls only when the sequencer falls behind. Reset clears
// the frame state, queue and output valid and sets the address byte to 0x05.
// ----------------------------------------------------------------------------
module info_frame_stuffing_encoder_core (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_ready,
   input  ifse_pkg::req_payload_type  req_payload,
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output ifse_pkg::rsp_payload_type  rsp_payload,
   input  wire                        csr_write_enable,
   input  wire  [7:0]                 csr_write_data
);
   import ifse_pkg::*;

   logic              push;
   cmd_type           push_cmd;
   logic              pop;
   queue_status_type  status;
   cmd_type           head_cmd;

   // Accept and classify transactions.
   ifse_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .queue_full       (status.full),
      .push             (push),
      .push_cmd         (push_cmd)
   );

   // Decouple front and back.
   ifse_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .status   (status),
      .head_cmd (head_cmd)
   );

   // Serialize commands to line bytes.
   ifse_back u_back (
      .clock       (clock),
      .reset       (reset),
      .status      (status),
      .head_cmd    (head_cmd),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule : info_frame_stuffing_encoder_core
`default_nettype wire

FILE: src/ifse_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ifse_front: input acceptance and frame classification
// Holds the address register and the frame state, decides whether a header
// is due, keeps the running BCC2 and pushes one command per transaction.
// ----------------------------------------------------------------------------
module ifse_front (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_ready,
   input  ifse_pkg::req_payload_type  req_payload,
   input  wire                        csr_write_enable,
   input  wire  [7:0]                 csr_write_data,
   input  wire                        queue_full,
   output logic                       push,
   output ifse_pkg::cmd_type          push_cmd
);
   import ifse_pkg::*;

   logic [7:0] addr_ff, addr_in;
   logic       frame_open_ff, frame_open_in;
   logic [7:0] parity_ff, parity_in;
   logic [7:0] parity_next;

   // A transaction is taken whenever the queue has room.
   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;

   // Build the command; a closed frame restarts the parity at zero.
   always_comb begin
      parity_next       = (frame_open_ff ? parity_ff : 8'h00) ^ req_payload.data_byte;
      push_cmd.header   = !frame_open_ff;
      push_cmd.addr     = addr_ff;
      push_cmd.ctrl     = req_payload.seq_bit ? CTRL_SEQ1 : CTRL_SEQ0;
      push_cmd.data     = req_payload.data_byte;
      push_cmd.last     = req_payload.frame_end;
      push_cmd.bcc2     = parity_next;
   end

   // Next-state logic for the address register and frame tracking.
   always_comb begin
      addr_in       = csr_write_enable ? csr_write_data : addr_ff;
      frame_open_in = frame_open_ff;
      parity_in     = parity_ff;
      if (push) begin
         frame_open_in = !req_payload.frame_end;
         parity_in     = req_payload.frame_end ? 8'h00 : parity_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff       <= ADDR_RESET;
         frame_open_ff <= 1'b0;
         parity_ff     <= 8'h00;
      end else begin
         addr_ff       <= addr_in;
         frame_open_ff <= frame_open_in;
         parity_ff     <= parity_in;
      end
   end

endmodule : ifse_front
`default_nettype wire

FILE: src/ifse_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ifse_queue: command queue between front end and back end
// A small register FIFO that lets the front end accept while the back end
// is still serializing or stalled by the result channel.
// ----------------------------------------------------------------------------
module ifse_queue (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          push,
   input  ifse_pkg::cmd_type            push_cmd,
   input  wire                          pop,
   output ifse_pkg::queue_status_type   status,
   output ifse_pkg::cmd_type            head_cmd
);
   import ifse_pkg::*;

   cmd_type                  entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;

   assign status.valid = (count_ff != '0);
   assign status.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_cmd     = entry_ff[rd_ptr_ff];

   // Pointer and fill count updates with wraparound.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule : ifse_queue
`default_nettype wire

FILE: src/ifse_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ifse_back: line byte sequencer
// Walks the head command through header, stuffed data, stuffed BCC2 and
// closing flag, one line byte per cycle into the output register when free.
// ----------------------------------------------------------------------------
module ifse_back (
   input  wire                          clock,
   input  wire                          reset,
   input  ifse_pkg::queue_status_type   status,
   input  ifse_pkg::cmd_type            head_cmd,
   output logic                         pop,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output ifse_pkg::rsp_payload_type    rsp_payload
);
   import ifse_pkg::*;

   state_type        state_ff, state_in;
   state_type        cur_state;
   state_type        next_state;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_payload_ff;
   rsp_payload_type  out_word;
   logic             load;
   logic             finish;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // A new byte goes out when there is work and the output register is free.
   assign load = status.valid && (!rsp_valid_ff || rsp_ready);
   assign pop  = load && finish;

   // A fresh command starts at the header or directly at its data byte.
   always_comb begin
      if (state_ff == ST_START) begin
         cur_state = head_cmd.header ? ST_FLAG_OPEN : ST_DATA;
      end else begin
         cur_state = state_ff;
      end
   end

   // Byte selection and step sequencing.
   always_comb begin
      out_word.line_byte  = FLAG_BYTE;
      out_word.frame_done = 1'b0;
      next_state          = ST_START;
      finish              = 1'b0;
      unique case (cur_state)
         ST_FLAG_OPEN: begin
            next_state = ST_ADDR;
         end
         ST_ADDR: begin
            out_word.line_byte = head_cmd.addr;
            next_state         = ST_CTRL;
         end
         ST_CTRL: begin
            out_word.line_byte = head_cmd.ctrl;
            next_state         = ST_BCC1;
         end
         ST_BCC1: begin
            out_word.line_byte = head_cmd.addr ^ head_cmd.ctrl;
            next_state         = ST_DATA;
         end
         ST_DATA: begin
            if (needs_escape(head_cmd.data)) begin
               out_word.line_byte = ESC_BYTE;
               next_state         = ST_DATA_ESC;
            end else begin
               out_word.line_byte = head_cmd.data;
               next_state         = head_cmd.last ? ST_BCC2 : ST_START;
               finish             = !head_cmd.last;
            end
         end
         ST_DATA_ESC: begin
            out_word.line_byte = head_cmd.data ^ ESC_XOR;
            next_state         = head_cmd.last ? ST_BCC2 : ST_START;
            finish             = !head_cmd.last;
         end
         ST_BCC2: begin
            if (needs_escape(head_cmd.bcc2)) begin
               out_word.line_byte = ESC_BYTE;
               next_state         = ST_BCC2_ESC;
            end else begin
               out_word.line_byte = head_cmd.bcc2;
               next_state         = ST_FLAG_CLOSE;
            end
         end
         ST_BCC2_ESC: begin
            out_word.line_byte = head_cmd.bcc2 ^ ESC_XOR;
            next_state         = ST_FLAG_CLOSE;
         end
         ST_FLAG_CLOSE: begin
            out_word.frame_done = 1'b1;
            next_state          = ST_START;
            finish              = 1'b1;
         end
         default: begin
            next_state = ST_START;
         end
      endcase
      out_word.burst_last = finish;
   end

   // Sequencer state and output valid.
   always_comb begin
      state_in     = load ? next_state : state_ff;
      rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_START;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_payload_ff <= out_word;
      end
   end

endmodule : ifse_back
`default_nettype wire

FILE: verif/info_frame_stuffing_encoder_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// info_frame_stuffing_encoder_core_tb: self-checking bench for the frame encoder
// Feeds payload bytes through the request channel in random bursts and checks
// every line byte against an in-bench encoder that builds the header, stuffs
// the payload and BCC2, and closes each frame. The address byte is changed
// between phases while the block is idle, and the result channel stalls at
// random, once for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module info_frame_stuffing_encoder_core_tb;
   import ifse_pkg::*;

   localparam int CYCLE_LIMIT    = 200000;
   localparam int LONG_HOLD      = 300;
   localparam int PHASE_COUNT    = 6;
   localparam int ITEMS_PER_PHASE = 64;
   localparam int MAX_BURST      = 9;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_MOSTLY,
      READY_RARELY
   } ready_mode_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_write_enable = 1'b0;
   logic [7:0]      csr_write_data = '0;

   // Transactions waiting to be offered, and line bytes waiting to be seen.
   req_payload_type payload_backlog [$];
   rsp_payload_type expected_line_q [$];
   int              mismatch_count = 0;

   // Encoder shadow state.
   logic [7:0]      address_shadow = ADDR_RESET;
   logic            frame_open_shadow = 1'b0;
   logic [7:0]      bcc2_shadow = '0;
   rsp_payload_type line_burst [MAX_BURST];
   int              burst_len;

   // Parity of the frame being generated, used to steer BCC2 onto escape bytes.
   logic [7:0]      gen_parity = '0;

   // Sender burst shaping.
   int              burst_left = 0;
   int              gap_left = 0;

   // Receiver stall pattern.
   ready_mode_type  ready_mode = READY_ALWAYS;
   int              stretch_left = 0;
   int              hold_left = 0;
   logic            hold_request = 1'b0;
   logic            hold_taken = 1'b0;

   info_frame_stuffing_encoder_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #2 clock = ~clock;

   // Append one line byte to the burst being built.
   task automatic add_line_byte(input logic [7:0] value, input logic done);
      line_burst[burst_len].line_byte  = value;
      line_burst[burst_len].burst_last = 1'b0;
      line_burst[burst_len].frame_done = done;
      burst_len++;
   endtask

   // Append a byte with flag and escape bytes escaped.
   task automatic add_stuffed(input logic [7:0] value);
      if (value == FLAG_BYTE || value == ESC_BYTE) begin
         add_line_byte(ESC_BYTE, 1'b0);
         add_line_byte(value ^ ESC_XOR, 1'b0);
      end else begin
         add_line_byte(value, 1'b0);
      end
   endtask

   // Work out the line bytes that one accepted payload byte produces.
   task automatic encode_payload_byte(input req_payload_type item);
      logic [7:0] ctrl;
      burst_len = 0;
      if (!frame_open_shadow) begin
         ctrl = item.seq_bit ? CTRL_SEQ1 : CTRL_SEQ0;
         add_line_byte(FLAG_BYTE, 1'b0);
         add_line_byte(address_shadow, 1'b0);
         add_line_byte(ctrl, 1'b0);
         add_line_byte(address_shadow ^ ctrl, 1'b0);
         bcc2_shadow = '0;
         frame_open_shadow = 1'b1;
      end
      add_stuffed(item.data_byte);
      bcc2_shadow = bcc2_shadow ^ item.data_byte;
      if (item.frame_end) begin
         add_stuffed(bcc2_shadow);
         add_line_byte(FLAG_BYTE, 1'b1);
         frame_open_shadow = 1'b0;
         bcc2_shadow = '0;
      end
      line_burst[burst_len - 1].burst_last = 1'b1;
      for (int i = 0; i < burst_len; i++) begin
         expected_line_q.push_back(line_burst[i]);
      end
   endtask

   // Queue one payload byte for the sender.
   task automatic queue_item(input logic [7:0] data, input logic last, input logic seq);
      req_payload_type item;
      item.data_byte = data;
      item.frame_end = last;
      item.seq_bit   = seq;
      payload_backlog.push_back(item);
      gen_parity = last ? 8'h00 : (gen_parity ^ data);
   endtask

   // Payload bytes lean toward the two bytes that need escaping.
   function automatic logic [7:0] pick_payload_byte();
      case ($urandom_range(0, 7))
         0:       pick_payload_byte = FLAG_BYTE;
         1:       pick_payload_byte = ESC_BYTE;
         default: pick_payload_byte = 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Mostly whole frames with random content; some stray bytes with random marks.
   task automatic queue_random_traffic(input int item_goal);
      int         queued;
      int         frame_len;
      logic [7:0] value;
      logic       last;
      queued = 0;
      while (queued < item_goal) begin
         if ($urandom_range(0, 6) == 0) begin
            queue_item(8'($urandom_range(0, 255)), $urandom_range(0, 2) == 0,
                       1'($urandom_range(0, 1)));
            queued++;
         end else begin
            frame_len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20)
                                                    : $urandom_range(1, 8);
            for (int i = 0; i < frame_len; i++) begin
               last  = (i == frame_len - 1);
               value = pick_payload_byte();
               // Now and then steer the check byte onto a flag or an escape.
               if (last && $urandom_range(0, 3) == 0) begin
                  value = gen_parity ^ (($urandom_range(0, 1) == 0) ? FLAG_BYTE : ESC_BYTE);
               end
               queue_item(value, last, 1'($urandom_range(0, 1)));
               queued++;
            end
         end
      end
   endtask

   // Wait until every transaction is accepted and every line byte has arrived.
   task automatic wait_for_drain();
      do begin
         @(negedge clock);
      end while (payload_backlog.size() != 0 || req_valid || expected_line_q.size() != 0);
   endtask

   // Write the address register; the block is idle here.
   task automatic write_address(input logic [7:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      address_shadow = value;
   endtask

   // Sender: offers the backlog in bursts with random gaps between them.
   always @(posedge clock) begin : drive_requests
      logic busy;
      busy = req_valid && !req_ready;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            void'(payload_backlog.pop_front());
         end
         if (!busy) begin
            if (gap_left > 0 || payload_backlog.size() == 0) begin
               req_valid <= 1'b0;
               if (gap_left > 0) begin
                  gap_left <= gap_left - 1;
               end
            end else begin
               req_valid   <= 1'b1;
               req_payload <= payload_backlog[0];
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 24);
                  gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end
         end
      end
   end

   // Receiver: random stall stretches, plus one long hold-off on request.
   always @(posedge clock) begin : drive_rsp_ready
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_request && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= LONG_HOLD;
         rsp_ready  <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         if (stretch_left == 0) begin
            stretch_left <= $urandom_range(4, 40);
            ready_mode   <= ready_mode_type'($urandom_range(0, 2));
         end else begin
            stretch_left <= stretch_left - 1;
         end
         case (ready_mode)
            READY_ALWAYS: rsp_ready <= 1'b1;
            READY_MOSTLY: rsp_ready <= ($urandom_range(0, 3) != 0);
            default:      rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Monitor: predict on each accepted payload byte, then check each line byte.
   always @(posedge clock) begin : check_line_bytes
      rsp_payload_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            encode_payload_byte(req_payload);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_line_q.size() == 0) begin
               $error("line byte %02h arrived with nothing expected", rsp_payload.line_byte);
               mismatch_count++;
            end else begin
               want = expected_line_q.pop_front();
               if (rsp_payload.line_byte !== want.line_byte) begin
                  $error("line_byte: expected %02h, got %02h",
                         want.line_byte, rsp_payload.line_byte);
                  mismatch_count++;
               end
               if (rsp_payload.burst_last !== want.burst_last) begin
                  $error("burst_last: expected %0b, got %0b",
                         want.burst_last, rsp_payload.burst_last);
                  mismatch_count++;
               end
               if (rsp_payload.frame_done !== want.frame_done) begin
                  $error("frame_done: expected %0b, got %0b",
                         want.frame_done, rsp_payload.frame_done);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // Watchdog on the whole run.
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAILURE");
      $finish;
   end

   // Stimulus: directed frames at the reset address, then random phases.
   initial begin : run_stimulus
      logic [7:0] phase_address [PHASE_COUNT];
      phase_address[0] = 8'h00;
      phase_address[1] = 8'hFF;
      phase_address[2] = FLAG_BYTE;
      phase_address[3] = ESC_BYTE;
      phase_address[4] = 8'($urandom_range(0, 255));
      phase_address[5] = 8'($urandom_range(0, 255));

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Single-byte frames at the data extremes and on both escape bytes.
      queue_item(8'h00, 1'b1, 1'b0);
      queue_item(8'hFF, 1'b1, 1'b1);
      queue_item(FLAG_BYTE, 1'b1, 1'b0);
      queue_item(ESC_BYTE, 1'b1, 1'b1);
      // Sequence bit changes mid-frame and must be ignored.
      queue_item(FLAG_BYTE, 1'b0, 1'b1);
      queue_item(ESC_BYTE, 1'b0, 1'b0);
      queue_item(8'h55, 1'b0, 1'b0);
      queue_item(8'hAA, 1'b1, 1'b0);
      // Check byte of zero.
      queue_item(8'h12, 1'b0, 1'b0);
      queue_item(8'h12, 1'b1, 1'b1);
      // Check byte that comes out as an escaped flag.
      queue_item(8'hA5, 1'b0, 1'b1);
      queue_item(8'hDB, 1'b1, 1'b0);
      // Check byte that comes out as an escaped escape.
      queue_item(8'h01, 1'b0, 1'b0);
      queue_item(8'h7C, 1'b1, 1'b1);
      // Back-to-back escapes inside one frame.
      queue_item(ESC_BYTE, 1'b0, 1'b0);
      queue_item(FLAG_BYTE, 1'b0, 1'b1);
      queue_item(FLAG_BYTE, 1'b0, 1'b0);
      queue_item(8'h80, 1'b1, 1'b0);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         wait_for_drain();
         write_address(phase_address[p]);
         @(negedge clock);
         if (p == 2) begin
            hold_request = 1'b1;
         end
         queue_random_traffic(ITEMS_PER_PHASE);
      end

      wait_for_drain();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && expected_line_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule : info_frame_stuffing_encoder_core_tb
